/* sv/hbr_pkg.sv */
`default_nettype none
package hbr_pkg;

   localparam int MAX_RADIUS    = 63;
   localparam int MAX_ROW_WIDTH = 4096;
   localparam int WIN_DEPTH     = 2 * MAX_RADIUS + 1;
   localparam int NUM_CHAN      = 4;
   localparam int RAD_W         = $clog2(MAX_RADIUS + 1);
   localparam int IDX_W         = $clog2(MAX_ROW_WIDTH);
   localparam int WADDR_W       = $clog2(WIN_DEPTH);
   localparam int TAP_W         = $clog2(WIN_DEPTH + 1);
   localparam int SUM_W         = 15;
   localparam int PIX_W         = 8 * NUM_CHAN;
   localparam int QBIT_W        = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD,
      ST_ACC,
      ST_DIVI,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic tap_clear;
      logic tap_rd;
      logic tap_acc;
      logic div_init;
      logic div_step;
      logic out_next;
   } cmd_type;

   typedef struct packed {
      logic has_out;
      logic tap_last;
      logic div_last;
      logic more;
   } status_type;

   // index modulo the window depth: 128 is 1 mod 127, so fold the top bits in
   function automatic logic [WADDR_W-1:0] win_addr(input logic [IDX_W-1:0] idx);
      logic [WADDR_W:0] s;
      s = {1'b0, idx[WADDR_W-1:0]} + {{(2 * WADDR_W + 1 - IDX_W){1'b0}}, idx[IDX_W-1:WADDR_W]};
      if (s >= (WADDR_W + 1)'(WIN_DEPTH)) begin
         s = s - (WADDR_W + 1)'(WIN_DEPTH);
      end
      return s[WADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* sv/hbr_ram.sv */
`default_nettype none
module hbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

/* sv/hbr_ctrl.sv */
`default_nettype none
module hbr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire hbr_pkg::status_type status,
   output      hbr_pkg::cmd_type    cmd
);

   hbr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbr_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = hbr_pkg::ST_CHECK;
         end
         hbr_pkg::ST_CHECK: begin
            state_in = status.has_out ? hbr_pkg::ST_RD : hbr_pkg::ST_IDLE;
         end
         hbr_pkg::ST_RD: state_in = hbr_pkg::ST_ACC;
         hbr_pkg::ST_ACC: begin
            state_in = status.tap_last ? hbr_pkg::ST_DIVI : hbr_pkg::ST_RD;
         end
         hbr_pkg::ST_DIVI: state_in = hbr_pkg::ST_DIV;
         hbr_pkg::ST_DIV: begin
            if (status.div_last) state_in = hbr_pkg::ST_OUT;
         end
         hbr_pkg::ST_OUT: begin
            if (rsp_tready) state_in = status.more ? hbr_pkg::ST_RD : hbr_pkg::ST_IDLE;
         end
         default: state_in = hbr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         hbr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         hbr_pkg::ST_CHECK: cmd.tap_clear = 1'b1;
         hbr_pkg::ST_RD:    cmd.tap_rd = 1'b1;
         hbr_pkg::ST_ACC:   cmd.tap_acc = 1'b1;
         hbr_pkg::ST_DIVI:  cmd.div_init = 1'b1;
         hbr_pkg::ST_DIV:   cmd.div_step = 1'b1;
         hbr_pkg::ST_OUT: begin
            rsp_tvalid   = 1'b1;
            cmd.out_next = rsp_tready & status.more;
         end
         default: cmd = '0;
      endcase
   end

   a_accept_goes_check: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == hbr_pkg::ST_CHECK)
      else $error("accepted item did not move to check");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled result dropped");

   a_div_to_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == hbr_pkg::ST_DIV && status.div_last |=> state_ff == hbr_pkg::ST_OUT)
      else $error("division end did not present result");

endmodule
`default_nettype wire

/* sv/hbr_dp.sv */
`default_nettype none
module hbr_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hbr_pkg::cmd_type              cmd,
   output      hbr_pkg::status_type           status,
   input  wire logic [hbr_pkg::RAD_W-1:0]     radius,
   input  wire logic [hbr_pkg::PIX_W-1:0]     pixel,
   input  wire logic                          row_end,
   output      logic [hbr_pkg::PIX_W-1:0]     out_pixel,
   output      logic                          out_row_done,
   output      logic                          out_run_last
);

   localparam int IW = hbr_pkg::IDX_W;
   localparam int TW = hbr_pkg::TAP_W;
   localparam int JW = IW + 2;

   logic [IW-1:0] n_ff, last_ff, x_ff;
   logic          end_ff;
   logic [hbr_pkg::PIX_W-1:0] first_ff;
   logic [TW-1:0] k_ff;
   logic          use_first_ff;
   logic [hbr_pkg::SUM_W-1:0] acc_ff [hbr_pkg::NUM_CHAN];
   logic [6:0]    rem_ff [hbr_pkg::NUM_CHAN];
   logic [7:0]    q_ff [hbr_pkg::NUM_CHAN];
   logic [hbr_pkg::QBIT_W-1:0] d_ff;

   logic          is_end;
   logic [TW-1:0] span;
   logic signed [JW-1:0] j;
   logic [IW-1:0] jc;
   logic [hbr_pkg::PIX_W-1:0] ram_rdata, tap_pix;

   assign span   = {radius, 1'b1};
   assign is_end = row_end || (n_ff == IW'(hbr_pkg::MAX_ROW_WIDTH - 1));

   assign j = $signed({2'b00, x_ff}) + $signed({{(JW - TW){1'b0}}, k_ff})
            - $signed({{(JW - hbr_pkg::RAD_W){1'b0}}, radius});

   always_comb begin
      if (j[JW-2:0] > {1'b0, last_ff}) begin
         jc = last_ff;
      end else begin
         jc = j[IW-1:0];
      end
   end

   hbr_ram #(
      .WIDTH(hbr_pkg::PIX_W),
      .DEPTH(hbr_pkg::WIN_DEPTH)
   ) u_win (
      .clock(clock),
      .we   (cmd.load),
      .waddr(hbr_pkg::win_addr(n_ff)),
      .wdata(pixel),
      .re   (cmd.tap_rd),
      .raddr(hbr_pkg::win_addr(jc)),
      .rdata(ram_rdata)
   );

   assign tap_pix = use_first_ff ? first_ff : ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else if (cmd.load) begin
         n_ff <= is_end ? '0 : n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         end_ff  <= is_end;
         last_ff <= n_ff;
         if (n_ff == '0) first_ff <= pixel;
         if (is_end && n_ff < {{(IW - hbr_pkg::RAD_W){1'b0}}, radius}) begin
            x_ff <= '0;
         end else begin
            x_ff <= n_ff - {{(IW - hbr_pkg::RAD_W){1'b0}}, radius};
         end
      end else if (cmd.out_next) begin
         x_ff <= x_ff + 1'b1;
      end
      if (cmd.tap_clear || cmd.out_next) begin
         k_ff <= '0;
      end else if (cmd.tap_acc) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.tap_rd) use_first_ff <= j[JW-1];
      if (cmd.div_init) begin
         d_ff <= '1;
      end else if (cmd.div_step) begin
         d_ff <= d_ff - 1'b1;
      end
   end

   for (genvar c = 0; c < hbr_pkg::NUM_CHAN; c++) begin : g_chan
      logic [7:0] t, diff;
      assign t    = {rem_ff[c], acc_ff[c][d_ff]};
      assign diff = t - {1'b0, span};

      always_ff @(posedge clock) begin
         if (cmd.tap_clear || cmd.out_next) begin
            acc_ff[c] <= '0;
         end else if (cmd.tap_acc) begin
            acc_ff[c] <= acc_ff[c] + {7'd0, tap_pix[8*c +: 8]};
         end
         if (cmd.div_init) begin
            rem_ff[c] <= acc_ff[c][hbr_pkg::SUM_W-1:8];
         end else if (cmd.div_step) begin
            if (t >= {1'b0, span}) begin
               rem_ff[c]     <= diff[6:0];
               q_ff[c][d_ff] <= 1'b1;
            end else begin
               rem_ff[c]     <= t[6:0];
               q_ff[c][d_ff] <= 1'b0;
            end
         end
      end
      assign out_pixel[8*c +: 8] = q_ff[c];
   end

   assign status.has_out  = end_ff || (last_ff >= {{(IW - hbr_pkg::RAD_W){1'b0}}, radius});
   assign status.tap_last = (k_ff == {radius, 1'b0});
   assign status.div_last = (d_ff == '0);
   assign status.more     = end_ff && (x_ff != last_ff);

   assign out_row_done = end_ff && (x_ff == last_ff);
   assign out_run_last = !end_ff || (x_ff == last_ff);

   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.tap_acc |-> k_ff < span)
      else $error("tap counter ran past window");

   a_x_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.tap_rd |-> x_ff <= last_ff)
      else $error("output index beyond row end");

   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> acc_ff[0][hbr_pkg::SUM_W-1:8] < span)
      else $error("quotient exceeds a byte");

endmodule
`default_nettype wire

/* sv/horizontal_box_blur_row_top.sv */
// Horizontal box blur of one row of four-byte pixels.
// req channel: one pixel per item, req_tlast marks the last pixel of a row.
// rsp channel: blurred pixels; rsp_tlast marks the last pixel of the row,
// rsp_tuser marks the last result caused by the current input item.
// csr channel: writes the blur radius r (0 acts as 1); write only while idle.
// Each result sums its 2r+1 window pixels one window memory read at a
// time and then runs an 8-step restoring divide by the span 2r+1.
// The end-of-row item yields up to r+1 results this way.
// One item is in work at a time; req_tready is low
// until its results have all been taken.
// The output for pixel x is emitted when pixel x+r arrives, edges clamped.
// Reset sets the radius to 1 and starts a new row; the window memory holds
// no reset value. A stalled receiver holds the result steady on rsp_tdata.
`default_nettype none
module horizontal_box_blur_row_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,  // chan0_in, chan1_in, chan2_in, chan3_in
   input  wire logic        req_tlast,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,  // chan0_out, chan1_out, chan2_out, chan3_out
   output      logic        rsp_tlast,
   output      logic        rsp_tuser,  // run_last
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [5:0]  csr_data
);

   logic [hbr_pkg::RAD_W-1:0] radius_ff;
   hbr_pkg::cmd_type    cmd;
   hbr_pkg::status_type status;

   assign csr_ready = 1'b1;

   // treat zero as one
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= hbr_pkg::RAD_W'(1);
      end else if (csr_valid) begin
         radius_ff <= (csr_data == '0) ? hbr_pkg::RAD_W'(1) : csr_data;
      end
   end

   hbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   hbr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .radius      (radius_ff),
      .pixel       (req_tdata),
      .row_end     (req_tlast),
      .out_pixel   (rsp_tdata),
      .out_row_done(rsp_tlast),
      .out_run_last(rsp_tuser)
   );

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;

   typedef struct packed {
      logic [31:0] pix;
      logic        row_end;
   } pixel_item_type;

   typedef struct packed {
      logic [31:0] pix;
      logic        row_done;
      logic        run_last;
   } blur_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // chan0_in, chan1_in, chan2_in, chan3_in
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // chan0_out, chan1_out, chan2_out, chan3_out
   logic        rsp_tlast;
   logic        rsp_tuser;        // run_last
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   horizontal_box_blur_row_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   pixel_item_type pending_pixels[$];
   blur_item_type  expected_blur[$];

   // predictor state
   logic [31:0] row_pixels[hbr_pkg::WIN_DEPTH];
   logic [31:0] first_pixel;
   int          pixel_pos = 0;
   logic [5:0]  radius_reg = 6'd1;

   int  mismatches = 0;
   int  pixels_sent = 0;
   int  blurs_seen = 0;
   int  rows_sent = 0;
   int  stall_cycles = 0;
   bit  req_took = 0;
   bit  quiet = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;

   function automatic blur_item_type blur_window(int x, int last_pos, int r, bit fin);
      int            acc[4];
      int            j;
      int            k;
      logic [31:0]   p;
      blur_item_type b;
      for (int c = 0; c < 4; c++) acc[c] = 0;
      for (j = x - r; j <= x + r; j++) begin
         if (j < 0) begin
            p = first_pixel;
         end else begin
            k = (j > last_pos) ? last_pos : j;
            p = row_pixels[k % hbr_pkg::WIN_DEPTH];
         end
         for (int c = 0; c < 4; c++) acc[c] += p[8*c +: 8];
      end
      for (int c = 0; c < 4; c++) b.pix[8*c +: 8] = 8'(acc[c] / (2 * r + 1));
      b.row_done = fin;
      b.run_last = fin;
      return b;
   endfunction

   task automatic predict_blur(pixel_item_type it);
      int            r;
      int            n;
      bit            row_end;
      blur_item_type b;
      r = (radius_reg == 0) ? 1 : int'(radius_reg);
      n = pixel_pos;
      row_end = it.row_end || (n >= hbr_pkg::MAX_ROW_WIDTH - 1);
      row_pixels[n % hbr_pkg::WIN_DEPTH] = it.pix;
      if (n == 0) first_pixel = it.pix;
      if (!row_end) begin
         pixel_pos = n + 1;
         if (n >= r) begin
            b = blur_window(n - r, n, r, 1'b0);
            b.run_last = 1'b1;
            expected_blur.push_back(b);
         end
      end else begin
         for (int x = (n >= r) ? n - r : 0; x <= n; x++)
            expected_blur.push_back(blur_window(x, n, r, x == n));
         pixel_pos = 0;
         rows_sent++;
      end
   endtask

   // driver: accepted pixels go to the predictor; the negedge block below drives req
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         req_took = 1;
         pixels_sent++;
         predict_blur('{req_tdata, req_tlast});
      end
   end

   always @(negedge clock) begin
      pixel_item_type it;
      if (!reset && !(req_tvalid && !req_took)) begin
         req_took = 0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            it = pending_pixels.pop_front();
            req_tdata  <= it.pix;
            req_tlast  <= it.row_end;
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 8);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      blur_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         blurs_seen++;
         if (expected_blur.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result pix=%h done=%b last=%b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = expected_blur.pop_front();
            if (rsp_tdata !== want.pix || rsp_tlast !== want.row_done ||
                rsp_tuser !== want.run_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want pix=%h done=%b last=%b, got pix=%h done=%b last=%b",
                           want.pix, want.row_done, want.run_last,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   // watchdog: no item moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= 40000) begin
         $display("FAIL horizontal_box_blur_row_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [31:0] pick_pixel();
      logic [31:0] p;
      p = $urandom;
      case ($urandom_range(0, 7))
         0: p = '0;
         1: p = '1;
         default: ;
      endcase
      return p;
   endfunction

   task automatic queue_row(int len, bit close_row);
      for (int i = 0; i < len; i++)
         pending_pixels.push_back('{pick_pixel(), close_row && (i == len - 1)});
   endtask

   task automatic drain();
      while (pending_pixels.size() > 0 || req_tvalid || expected_blur.size() > 0)
         @(posedge clock);
      // an item that yields nothing may still be in work
      repeat (12) @(posedge clock);
   endtask

   task automatic write_radius(logic [5:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      radius_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int          r;
      int          len;
      int          room;
      logic [5:0]  rv;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, short rows, radius edges, radius change mid-row
      pending_pixels.push_back('{32'h0000_0000, 1'b0});
      pending_pixels.push_back('{32'hFFFF_FFFF, 1'b0});
      pending_pixels.push_back('{32'h00FF_00FF, 1'b0});
      pending_pixels.push_back('{32'hFF00_FF00, 1'b1});
      pending_pixels.push_back('{32'h1234_5678, 1'b1});
      drain();
      write_radius(6'd0);
      queue_row(3, 1);
      drain();
      write_radius(6'd63);
      queue_row(5, 1);
      drain();
      write_radius(6'd2);
      queue_row(6, 0);
      drain();
      write_radius(6'd5);
      queue_row(3, 0);
      drain();
      write_radius(6'd1);
      queue_row(3, 1);
      drain();

      // random: radius per phase, mostly small rows, a few long ones
      while (pixels_sent < 430) begin
         case ($urandom_range(0, 5))
            0: rv = 6'd63;
            1: rv = 6'($urandom_range(0, 63));
            default: rv = 6'($urandom_range(1, 6));
         endcase
         write_radius(rv);
         r = (rv == 0) ? 1 : rv;
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(128, 200);
            else len = $urandom_range(1, 2 * r + 8 > 40 ? 40 : 2 * r + 8);
            room = 430 - pixels_sent - int'(pending_pixels.size());
            if (len > room) len = room;
            if (len > 0) queue_row(len, 1);
         end
         drain();
      end

      quiet = 1;
      write_radius(6'd3);
      queue_row(20, 1);
      queue_row(9, 1);
      drain();
      repeat (50) @(posedge clock);

      $display("sent %0d pixels in %0d rows, checked %0d blurred pixels",
               pixels_sent, rows_sent, blurs_seen);
      $display("radii 0, 1, 63 and random, short rows and rows past the window depth, mid-row radius change");
      if (mismatches == 0 && expected_blur.size() == 0) begin
         $display("PASS horizontal_box_blur_row_top");
      end else begin
         $display("FAIL horizontal_box_blur_row_top");
      end
      $finish;
   end

endmodule
